// File: hw/rtl/gmfp_pkg.sv
// ============================================================================
// gmfp_pkg: shared types and constants for the minimum falling path block
// Holds the cell classification flags, the register map and the sum limits
// used by the front end, the queue and the back end.
// ============================================================================
package gmfp_pkg;

  // Default sizing handed down from the top level.
  localparam int MAX_SIZE_DEFAULT    = 64;
  localparam int COST_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Path sums are held and reported at this width and saturate at its maximum.
  localparam int             SUM_BITS = 22;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  // Configuration register map: one bit of register index above the byte offset.
  localparam int            GRID_SIZE_BITS  = 7;
  localparam logic          REG_GRID_SIZE   = 1'b0;
  localparam logic [GRID_SIZE_BITS-1:0] GRID_SIZE_RESET = 7'd8;

  // Classification of one cell, worked out by the front end.
  typedef struct packed {
    logic first_row;  // cell lies in the top row: no predecessor
    logic last_row;   // cell lies in the bottom row: candidate for the minimum
    logic grid_end;   // last cell of the grid: the result follows it
  } cell_flags_t;

endpackage

// File: hw/rtl/gmfp_front.sv
// ============================================================================
// gmfp_front: cell acceptance and classification
// Tracks the row and column of the next cell, clamps the configured size
// and tags every accepted cell with its column and position flags.
// ============================================================================
module gmfp_front import gmfp_pkg::*; #(
  parameter int  MAX_SIZE  = MAX_SIZE_DEFAULT,
  parameter int  COST_BITS = COST_BITS_DEFAULT,
  localparam int COL_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [GRID_SIZE_BITS-1:0] grid_size,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COST_BITS-1:0]      cell_cost,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [COST_BITS-1:0]      q_cost,
  output logic [COL_W-1:0]          q_col,
  output cell_flags_t               q_flags
);

  localparam int CMP_W  = COL_W + 1;
  localparam int SIZE_W = (GRID_SIZE_BITS > CMP_W) ? GRID_SIZE_BITS : CMP_W;

  logic [COL_W-1:0]  row;
  logic [COL_W-1:0]  row_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [SIZE_W-1:0] size_ext;
  logic [SIZE_W-1:0] size_eff;
  logic [CMP_W-1:0]  size_cmp;
  logic [CMP_W-1:0]  row_plus;
  logic [CMP_W-1:0]  col_plus;
  logic              last_row;
  logic              last_col;
  logic              accept;

  // Effective size: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    size_ext = SIZE_W'(grid_size);
    if (size_ext == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_ext > SIZE_W'(MAX_SIZE)) begin
      size_eff = SIZE_W'(MAX_SIZE);
    end else begin
      size_eff = size_ext;
    end
    size_cmp = size_eff[CMP_W-1:0];
  end

  // Position of the current cell within the grid.
  assign row_plus = {1'b0, row} + CMP_W'(1);
  assign col_plus = {1'b0, col} + CMP_W'(1);
  assign last_row = (row_plus >= size_cmp);
  assign last_col = (col_plus >= size_cmp);

  // A cell is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign q_push            = accept;
  assign q_cost            = cell_cost;
  assign q_col             = col;
  assign q_flags.first_row = (row == '0);
  assign q_flags.last_row  = last_row;
  assign q_flags.grid_end  = last_row && last_col;

  // Raster advance: column first, then row, wrapping at the end of the grid.
  always_comb begin
    row_next = row;
    col_next = col;
    if (accept) begin
      if (last_col) begin
        col_next = '0;
        row_next = last_row ? '0 : row_plus[COL_W-1:0];
      end else begin
        col_next = col_plus[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row <= '0;
      col <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

// File: hw/rtl/gmfp_queue.sv
// ============================================================================
// gmfp_queue: short first-in first-out queue between front and back end
// Holds classified cells so that either side can stall without the other.
// ============================================================================
module gmfp_queue import gmfp_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output logic [DATA_W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];

  // Pointer and occupancy tracking; the depth is a power of two so pointers wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// File: hw/rtl/gmfp_back.sv
// ============================================================================
// gmfp_back: path sum evaluation and result register
// Reads the previous row's best sum from the row store, adds the cell cost
// to the better predecessor, writes the new best sum back and keeps the
// least bottom-row sum until the grid ends.
// ============================================================================
module gmfp_back import gmfp_pkg::*; #(
  parameter int  MAX_SIZE  = MAX_SIZE_DEFAULT,
  parameter int  COST_BITS = COST_BITS_DEFAULT,
  localparam int COL_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [COST_BITS-1:0] q_cost,
  input  logic [COL_W-1:0]    q_col,
  input  cell_flags_t         q_flags,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SUM_BITS-1:0] min_path_sum
);

  localparam int PSUM_W = ((SUM_BITS > COST_BITS) ? SUM_BITS : COST_BITS) + 1;

  logic [SUM_BITS-1:0]  row_mem [MAX_SIZE];
  logic [SUM_BITS-1:0]  up_data;
  logic                 b_valid;
  logic [COST_BITS-1:0] b_cost;
  logic [COL_W-1:0]     b_col;
  cell_flags_t          b_flags;
  logic                 b_done;
  logic [SUM_BITS-1:0]  diag;
  logic [SUM_BITS-1:0]  pred;
  logic [SUM_BITS-1:0]  base;
  logic [PSUM_W-1:0]    sum;
  logic [SUM_BITS-1:0]  best;
  logic [SUM_BITS-1:0]  running_min;
  logic [SUM_BITS-1:0]  min_next;
  logic                 out_valid_next;

  // The cell in evaluation completes unless it carries a result that cannot be placed.
  assign b_done = b_valid && (!b_flags.grid_end || !out_valid || !out_stall);
  assign q_pop  = q_valid && (!b_valid || b_done);

  // Row store: the read of the popped cell's column and the write of the finished cell.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      up_data <= row_mem[q_col];
    end
    if (b_done) begin
      row_mem[b_col] <= best;
    end
  end

  // Evaluation stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (q_pop) begin
      b_valid <= 1'b1;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_cost  <= q_cost;
      b_col   <= q_col;
      b_flags <= q_flags;
    end
  end

  // Best sum: cost plus the smaller of the sum above and the sum above-left (zero in the top row), saturated.
  always_comb begin
    pred = up_data;
    if ((b_col != '0) && (diag < up_data)) begin
      pred = diag;
    end
    base = b_flags.first_row ? '0 : pred;
    sum  = PSUM_W'(base) + PSUM_W'(b_cost);
    if (sum > PSUM_W'(SUM_MAX)) begin
      best = SUM_MAX;
    end else begin
      best = sum[SUM_BITS-1:0];
    end
    min_next = (b_flags.last_row && (best < running_min)) ? best : running_min;
  end

  // The sum above this cell becomes the above-left sum of the next cell in the row.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      diag <= '0;
    end else if (b_done && !b_flags.first_row) begin
      diag <= up_data;
    end
  end

  // Least bottom-row sum, cleared when a grid ends or restarts.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      running_min <= SUM_MAX;
    end else if (b_done) begin
      running_min <= b_flags.grid_end ? SUM_MAX : min_next;
    end
  end

  // Result register: loaded at the end of a grid, cleared once the transaction completes.
  always_comb begin
    if (b_done && b_flags.grid_end) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (b_done && b_flags.grid_end) begin
      min_path_sum <= min_next;
    end
  end

endmodule

// File: hw/rtl/grid_min_falling_path_sum_top.sv
// ============================================================================
// grid_min_falling_path_sum_top: minimum falling path sum over a square grid
// Streams cell costs of an N by N grid and reports the least path sum from
// the top row to the bottom row, moving down or down-right.
// ============================================================================
// Usage:
//   Cell costs enter in row-major order on in_valid / in_stall / cell_cost,
//   one transaction per cell. After the last cell of a grid one transaction
//   leaves on out_valid / out_stall / min_path_sum carrying the least
//   bottom-row path sum, saturated at the 22-bit maximum.
//   N is set by grid_size (byte address 0 of the APB port, reset value 8);
//   zero acts as one and values above MAX_SIZE act as MAX_SIZE. Any write
//   to it restarts the grid at the top-left cell; write it only when idle.
//   Throughput is one cell per cycle unless a held result stalls the
//   back end, set by the single read and single write of the row store
//   per cell. The result register follows the queue and the back end.
//   When the receiver stalls, the result is held and cells keep flowing
//   until the next grid end reaches the back end; the four-entry queue then
//   fills and in_stall rises.
//   Reset is synchronous: it empties the queue, drops any pending result
//   and returns the position to the top-left cell. The row store needs no
//   clearing, as each grid's top row writes every entry it later reads.
// ============================================================================
module grid_min_falling_path_sum_top import gmfp_pkg::*; #(
  parameter int MAX_SIZE  = MAX_SIZE_DEFAULT,
  parameter int COST_BITS = COST_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COST_BITS-1:0] cell_cost,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SUM_BITS-1:0]  min_path_sum
);

  localparam int COL_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int FLAG_W = $bits(cell_flags_t);
  localparam int Q_W    = FLAG_W + COL_W + COST_BITS;

  logic [GRID_SIZE_BITS-1:0] grid_size;
  logic                      cfg_write;
  logic                      restart;
  logic                      q_full;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_valid;
  logic [COST_BITS-1:0]      f_cost;
  logic [COL_W-1:0]          f_col;
  cell_flags_t               f_flags;
  logic [Q_W-1:0]            q_wdata;
  logic [Q_W-1:0]            q_rdata;
  logic [COST_BITS-1:0]      b_cost;
  logic [COL_W-1:0]          b_col;
  cell_flags_t               b_flags;

  // Configuration port: the register index sits above the byte offset.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign restart   = cfg_write && (paddr[2] == REG_GRID_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RESET;
    end else if (restart) begin
      grid_size <= pwdata[GRID_SIZE_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_GRID_SIZE) begin
      prdata = 32'(grid_size);
    end else begin
      prdata = '0;
    end
  end

  // Front end: acceptance and classification.
  gmfp_front #(
    .MAX_SIZE  (MAX_SIZE),
    .COST_BITS (COST_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .grid_size (grid_size),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cell_cost (cell_cost),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cost    (f_cost),
    .q_col     (f_col),
    .q_flags   (f_flags)
  );

  // Queue between the two halves.
  assign q_wdata = {f_flags, f_col, f_cost};
  assign {b_flags, b_col, b_cost} = q_rdata;

  gmfp_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH_DEFAULT)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  // Back end: path sum evaluation and result.
  gmfp_back #(
    .MAX_SIZE  (MAX_SIZE),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cost       (b_cost),
    .q_col        (b_col),
    .q_flags      (b_flags),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .min_path_sum (min_path_sum)
  );

endmodule

// File: hw/rtl/gmfp_checker.sv
// ============================================================================
// gmfp_checker: port-level checks for the minimum falling path block
// Watches the top level's ports and flags reset, timing and readback slips.
// ============================================================================
module gmfp_checker import gmfp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                psel,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         prdata,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SUM_BITS-1:0] min_path_sum
);

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_path_sum))
    else $error("stalled result changed or vanished");

  // Reset empties the queue and drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("queue or result register not cleared by reset");

  // A result cannot rise straight out of reset: a cell must pass the back end first.
  a_result_latency: assert property (@(posedge clk)
    $rose(out_valid) |-> $past(!rst, 1) && $past(!rst, 2))
    else $error("result appeared too soon after reset");

  // The size register reads back with its unused bits clear.
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && (paddr[2] == REG_GRID_SIZE) |-> prdata[31:GRID_SIZE_BITS] == '0)
    else $error("size register readback has stray upper bits");

endmodule

bind grid_min_falling_path_sum_top gmfp_checker u_checker (.*);

// File: bench/grid_min_falling_path_sum_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// grid_min_falling_path_sum_top_tb: self-checking bench for the path sum block
// Streams square grids of cell costs into the block under bursty input and a
// stalling receiver, predicts each grid's least falling path sum in the bench
// and checks every result transaction in order. The grid size is rewritten
// over the APB port between phases, from zero up to values beyond the store.
// ============================================================================
module grid_min_falling_path_sum_top_tb;
  import gmfp_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int RANDOM_CELLS = 1400;
  localparam int SETTLE_CYCLES = 12;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [15:0]         cell_cost = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SUM_BITS-1:0] min_path_sum;

  grid_min_falling_path_sum_top dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cell_cost    (cell_cost),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .min_path_sum (min_path_sum)
  );

  // Clock and a single reset at the start of the run.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Cell costs waiting to be sent, and path sums waiting to come out.
  logic [15:0]         pending_cells[$];
  logic [SUM_BITS-1:0] expected_sums[$];
  int                  mismatches = 0;

  // Bench copy of the block's state.
  logic [SUM_BITS-1:0]       path_best[STORE_DEPTH];
  logic [SUM_BITS-1:0]       diag_best = '0;
  logic [5:0]                cur_row = '0;
  logic [5:0]                cur_col = '0;
  logic [SUM_BITS-1:0]       bottom_min = SUM_MAX;
  logic [GRID_SIZE_BITS-1:0] size_reg = GRID_SIZE_RESET;

  function automatic int grid_edge(input logic [GRID_SIZE_BITS-1:0] value);
    if (value == 0) return 1;
    if (value > STORE_DEPTH) return STORE_DEPTH;
    return int'(value);
  endfunction

  task automatic restart_path();
    diag_best  = '0;
    cur_row    = '0;
    cur_col    = '0;
    bottom_min = SUM_MAX;
  endtask

  // Folds one accepted cell into the row of best sums; a grid end queues its minimum.
  task automatic fold_cell(input logic [15:0] cost);
    int                  n;
    logic [5:0]          col;
    logic [SUM_BITS-1:0] above;
    logic [SUM_BITS-1:0] pred;
    logic [SUM_BITS-1:0] best;
    logic [SUM_BITS:0]   total;
    n   = grid_edge(size_reg);
    col = cur_col;
    if (cur_row == 0) begin
      total = {7'd0, cost};
    end else begin
      above = path_best[col];
      pred  = above;
      if (col != 0 && diag_best < pred) pred = diag_best;
      total     = {1'b0, pred} + {7'd0, cost};
      diag_best = above;
    end
    best = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_BITS-1:0];
    path_best[col] = best;
    if (int'(cur_row) + 1 >= n && best < bottom_min) bottom_min = best;
    if (int'(col) + 1 >= n) begin
      cur_col = '0;
      if (int'(cur_row) + 1 >= n) begin
        expected_sums.push_back(bottom_min);
        restart_path();
      end else begin
        cur_row = cur_row + 1'b1;
      end
    end else begin
      cur_col = col + 1'b1;
    end
  endtask

  // Input driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      cell_cost  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) fold_cell(cell_cost);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cells.size() != 0) begin
          in_valid  <= 1'b1;
          cell_cost <= pending_cells.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 15) == 0) gap_left <= $urandom_range(10, 24);
            else if ($urandom_range(0, 1) == 0) gap_left <= 0;
            else gap_left <= $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here and started on request from the sequence.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= 500;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall pattern: stretches of no stalling, light stalling and heavy stalling.
  int stall_mode = 0;
  int stall_run = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_run  <= 0;
    end else begin
      if (stall_run == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_run  <= $urandom_range(10, 80);
      end else begin
        stall_run <= stall_run - 1;
      end
      if (hold_left != 0) out_stall <= 1'b1;
      else if (stall_mode == 1) out_stall <= ($urandom_range(0, 1) == 0);
      else if (stall_mode == 2) out_stall <= ($urandom_range(0, 3) != 0);
      else out_stall <= 1'b0;
    end
  end

  // Result monitor: each result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual %0d", $time, min_path_sum);
      end else if (min_path_sum !== expected_sums[0]) begin
        mismatches++;
        $display("%0t: min_path_sum mismatch: expected %0d, actual %0d",
                 $time, expected_sums[0], min_path_sum);
        void'(expected_sums.pop_front());
      end else begin
        void'(expected_sums.pop_front());
      end
    end
  end

  function automatic logic [15:0] pick_cost(input int style);
    case (style)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 15));
      2: return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'hFFFF;
      default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom());
    endcase
  endfunction

  task automatic push_cells(input int count, input int style);
    for (int i = 0; i < count; i++) pending_cells.push_back(pick_cost(style));
  endtask

  // Waits until every queued cell is sent and every result is in, then lets the block settle.
  task automatic drain(input int settle);
    @(negedge clk);
    while (pending_cells.size() != 0 || in_valid || expected_sums.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic read_size(input logic [GRID_SIZE_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_GRID_SIZE, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== {25'd0, value}) begin
      mismatches++;
      $display("%0t: grid_size readback mismatch: expected %0d, actual %0d",
               $time, value, prdata);
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write; the bench state follows at the edge that completes the access.
  task automatic write_size(input logic [GRID_SIZE_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_GRID_SIZE, 2'b00};
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    size_reg = value;
    restart_path();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_size(value);
  endtask

  // Test sequence.
  initial begin
    int rand_cells;
    int r;
    int n;
    int grids;
    int style;
    int partial;
    logic [GRID_SIZE_BITS-1:0] size_pick;
    rand_cells = 0;
    drain(2);
    read_size(GRID_SIZE_RESET);

    // Size zero behaves as a one by one grid: each cell is a result.
    write_size(7'd0);
    pending_cells.push_back(16'hFFFF);
    pending_cells.push_back(16'h0000);
    drain(SETTLE_CYCLES);

    // Two by two grids: one where straight down wins, one where the diagonal wins.
    write_size(7'd2);
    pending_cells.push_back(16'd5);
    pending_cells.push_back(16'd1);
    pending_cells.push_back(16'd2);
    pending_cells.push_back(16'd9);
    pending_cells.push_back(16'd1);
    pending_cells.push_back(16'd9);
    pending_cells.push_back(16'd9);
    pending_cells.push_back(16'd2);
    drain(SETTLE_CYCLES);

    // Three by three grid of maximum costs.
    write_size(7'd3);
    for (int i = 0; i < 9; i++) pending_cells.push_back(16'hFFFF);
    drain(SETTLE_CYCLES);

    // A size write in the middle of a grid restarts it at the top-left cell.
    write_size(7'd2);
    pending_cells.push_back(16'd7);
    drain(SETTLE_CYCLES);
    write_size(7'd2);
    pending_cells.push_back(16'd3);
    pending_cells.push_back(16'd4);
    pending_cells.push_back(16'd0);
    pending_cells.push_back(16'hFFFF);
    drain(SETTLE_CYCLES);

    // One by one grids under a long receiver hold-off, so the block fills and stalls.
    write_size(7'd1);
    hold_requests++;
    push_cells(80, 0);
    drain(SETTLE_CYCLES);

    // Random phases: mostly complete grids, sometimes a broken grid at the end.
    while (rand_cells < RANDOM_CELLS) begin
      r = $urandom_range(0, 99);
      if (r < 3) size_pick = 7'd0;
      else if (r < 70) size_pick = 7'($urandom_range(1, 8));
      else if (r < 95) size_pick = 7'($urandom_range(9, 16));
      else size_pick = 7'($urandom_range(17, 24));
      write_size(size_pick);
      n = grid_edge(size_pick);
      grids = $urandom_range(1, 6);
      for (int g = 0; g < grids && rand_cells < RANDOM_CELLS; g++) begin
        style = $urandom_range(0, 3);
        push_cells(n * n, style);
        rand_cells += n * n;
        // Now and then the sender waits for every result before the next grid.
        if ($urandom_range(0, 4) == 0) drain(0);
      end
      if (n > 1 && $urandom_range(0, 6) == 0) begin
        style = $urandom_range(0, 3);
        partial = $urandom_range(1, n * n - 1);
        push_cells(partial, style);
        rand_cells += partial;
      end
      drain(SETTLE_CYCLES);
    end

    // Largest sizes: a broken grid at the full store, then a broken oversized grid.
    write_size(7'd64);
    push_cells(3 * STORE_DEPTH, 0);
    drain(SETTLE_CYCLES);
    write_size(7'd127);
    push_cells(2 * STORE_DEPTH, 2);
    drain(SETTLE_CYCLES);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gmfp_pkg.sv
hw/rtl/gmfp_front.sv
hw/rtl/gmfp_queue.sv
hw/rtl/gmfp_back.sv
hw/rtl/grid_min_falling_path_sum_top.sv
hw/rtl/gmfp_checker.sv
bench/grid_min_falling_path_sum_top_tb.sv
